[hw/rtl/lcd_pkg.sv]
`default_nettype none

package lcd_pkg;

    // item and result field widths
    localparam int X_W    = 16;   // log energy, Q5.10
    localparam int W_W    = 18;   // weight, Q3.14
    localparam int ACC_W  = 40;   // accumulator, Q15.24
    localparam int OUT_W  = 24;   // cepstrum, Q13.10
    localparam int IDX_W  = 4;    // coef_index

    // digit-serial multiply: the energy goes in as four 4-bit digits
    localparam int DIG_W     = 4;
    localparam int NUM_DIG   = X_W / DIG_W;
    localparam int DIG_CNT_W = $clog2(NUM_DIG);
    localparam logic [DIG_CNT_W-1:0] LAST_DIG = DIG_CNT_W'(NUM_DIG - 1);

    // output rounding: Q15.24 -> Q13.10, round half up
    localparam int FRAC_DROP  = 14;
    localparam int ROUND_HALF = 8192;

    // build-time weight generation (elaboration only)
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint          W_MAX   = 131071;

    // restoring long division, unsigned
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        logic [64:0]     rem;
        longint unsigned q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // cos(pi*p/q) in Q30, Taylor series in the first quadrant
    function automatic longint cos_q30(input longint unsigned p_in,
                                       input longint unsigned q);
        logic            neg;
        longint unsigned p;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned den;
        longint          sum;
        neg = 1'b0;
        p   = p_in - udiv(p_in, 2 * q) * (2 * q);
        if (p > q)
            p = 2 * q - p;
        if (2 * p > q) begin
            p   = q - p;
            neg = 1'b1;
        end
        x    = udiv(PI_Q30 * p, q);
        x2   = (x * x + (ONE_Q30 >> 1)) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (int k = 1; k <= 10; k++) begin
            den  = longint'(unsigned'((2 * k - 1) * (2 * k)));
            term = udiv((term * x2) >> 30, den);
            if ((k % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return neg ? -sum : sum;
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned bt;
        v  = v_in;
        r  = '0;
        bt = 64'd1 << 62;
        for (int n = 0; n < 32; n++) begin
            if (bt > v)
                bt = bt >> 2;
        end
        for (int n = 0; n < 32; n++) begin
            if (bt != 0) begin
                if (v >= r + bt) begin
                    v = v - (r + bt);
                    r = (r >> 1) + bt;
                end else begin
                    r = r >> 1;
                end
                bt = bt >> 2;
            end
        end
        return r;
    endfunction

    // liftered orthonormal DCT-II weight, Q3.14, saturated
    function automatic logic signed [W_W-1:0] weight_q14(input int nb,
                                                         input int i,
                                                         input int j);
        longint unsigned k;
        longint unsigned scale;
        longint          s;
        longint          lift;
        longint          c;
        logic            neg;
        longint unsigned mag;
        longint          w;
        k     = (i == 0) ? 64'd1 : 64'd2;
        scale = isqrt64(udiv(k << 60, longint'(unsigned'(nb))));
        s     = cos_q30((i > 11) ? longint'(unsigned'(i - 11)) : longint'(unsigned'(11 - i)),
                        64'd22);
        lift  = longint'(ONE_Q30) + 11 * s;
        if (lift < 0)
            lift = 0;
        c   = cos_q30(longint'(unsigned'(i)) * longint'(unsigned'(2 * j + 1)),
                      2 * longint'(unsigned'(nb)));
        neg = (c < 0);
        mag = neg ? longint'(-c) : longint'(c);
        mag = (mag * scale + (ONE_Q30 >> 1)) >> 30;
        mag = (mag * longint'(lift) + (64'd1 << 45)) >> 46;
        if (mag > longint'(W_MAX + 1))
            mag = longint'(W_MAX + 1);
        w = neg ? -longint'(mag) : longint'(mag);
        if (w > W_MAX)
            w = W_MAX;
        return w[W_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lcd_wrom.sv]
`default_nettype none

module lcd_wrom #(
    parameter int NUM_BINS = 23,
    parameter int NUM_CEPS = 13,
    parameter int CEP_W    = 4,
    parameter int BIN_W    = 5
) (
    input  wire logic                             i_clk,
    input  wire logic [CEP_W-1:0]                 i_cep,
    input  wire logic [BIN_W-1:0]                 i_bin,
    output logic signed [lcd_pkg::W_W-1:0]        o_weight
);

    logic signed [lcd_pkg::W_W-1:0] rom [NUM_CEPS][NUM_BINS];
    logic signed [lcd_pkg::W_W-1:0] r_weight;

    for (genvar gc = 0; gc < NUM_CEPS; gc++) begin : g_cep
        for (genvar gb = 0; gb < NUM_BINS; gb++) begin : g_bin
            localparam logic signed [lcd_pkg::W_W-1:0] W =
                lcd_pkg::weight_q14(NUM_BINS, gc, gb);
            assign rom[gc][gb] = W;
        end
    end

    always_ff @(posedge i_clk) begin
        r_weight <= rom[i_cep][i_bin];
    end

    assign o_weight = r_weight;

endmodule

`default_nettype wire

[hw/rtl/liftered_dct_cepstrum_top.sv]
`default_nettype none

// Liftered DCT cepstrum. Feed one log mel energy (Q5.10) per item with start,
// in bin order; an item is taken when start is high and busy is low. Each item
// runs one multiply-accumulate per cepstral index, and the multiply goes one
// 4-bit digit of the energy per cycle, and busy stays high after the accept
// while its multiply-accumulates run. After the last bin of a
// frame the block emits NUM_CEPS coefficients (Q13.10, rounded, saturated) on
// consecutive cycles, one per cycle with o_strobe, index 0 first, o_last_coef
// on the final one; busy stays high until the final coefficient is on the
// ports, and the next item can be taken at the edge that ends that cycle.
// Results must be taken when strobed: there is no way to stall them.

module liftered_dct_cepstrum_top #(
    parameter int NUM_BINS = 23,
    parameter int NUM_CEPS = 13
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [lcd_pkg::X_W-1:0]      i_log_energy,
    output logic                                     o_strobe,
    output logic [lcd_pkg::IDX_W-1:0]                o_coef_index,
    output logic signed [lcd_pkg::OUT_W-1:0]         o_cepstrum,
    output logic                                     o_last_coef
);

    localparam int CEP_W = (NUM_CEPS > 1) ? $clog2(NUM_CEPS) : 1;
    localparam int BIN_W = $clog2(NUM_BINS);
    localparam logic [CEP_W-1:0] LAST_CEP = CEP_W'(NUM_CEPS - 1);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);
    localparam int X_W   = lcd_pkg::X_W;
    localparam int W_W   = lcd_pkg::W_W;
    localparam int ACC_W = lcd_pkg::ACC_W;
    localparam int OUT_W = lcd_pkg::OUT_W;
    localparam int DIG_W = lcd_pkg::DIG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT
    } t_state;

    t_state                          r_state;
    logic signed [X_W-1:0]           r_x;
    logic [lcd_pkg::DIG_CNT_W-1:0]   r_dig;
    logic [CEP_W-1:0]                r_cep;
    logic [BIN_W-1:0]                r_bin;
    logic signed [ACC_W-1:0]         r_acc [NUM_CEPS];
    logic                            r_strobe;
    logic [CEP_W-1:0]                r_idx;
    logic signed [OUT_W-1:0]         r_ceps;
    logic                            r_last;

    logic [CEP_W-1:0]                rom_cep;
    logic signed [W_W-1:0]           weight;
    logic signed [DIG_W:0]           digit_s;
    logic signed [W_W+DIG_W:0]       prod;
    logic signed [ACC_W-1:0]         term;
    logic signed [ACC_W-1:0]         acc_sel;
    logic signed [ACC_W-1:0]         rounded;
    logic signed [OUT_W-1:0]         sat;

    // weight for the next MAC is addressed in the cycle before it is used
    always_comb begin
        rom_cep = '0;
        if (r_state == ST_MAC) begin
            if (r_dig == lcd_pkg::LAST_DIG)
                rom_cep = (r_cep == LAST_CEP) ? '0 : r_cep + CEP_W'(1);
            else
                rom_cep = r_cep;
        end
    end

    lcd_wrom #(
        .NUM_BINS (NUM_BINS),
        .NUM_CEPS (NUM_CEPS),
        .CEP_W    (CEP_W),
        .BIN_W    (BIN_W)
    ) u_wrom (
        .i_clk    (i_clk),
        .i_cep    (rom_cep),
        .i_bin    (r_bin),
        .o_weight (weight)
    );

    // one digit of the energy per cycle, top digit signed
    always_comb begin
        if (r_dig == lcd_pkg::LAST_DIG)
            digit_s = {r_x[DIG_W-1], r_x[DIG_W-1:0]};
        else
            digit_s = {1'b0, r_x[DIG_W-1:0]};
        prod    = weight * digit_s;
        term    = ACC_W'(prod) <<< {r_dig, 2'b00};
        acc_sel = r_acc[r_cep];
    end

    // round half up, drop 14 fraction bits, saturate
    always_comb begin
        rounded = (acc_sel + ACC_W'(lcd_pkg::ROUND_HALF)) >>> lcd_pkg::FRAC_DROP;
        if (&rounded[ACC_W-1:OUT_W-1] || ~|rounded[ACC_W-1:OUT_W-1])
            sat = rounded[OUT_W-1:0];
        else if (rounded[ACC_W-1])
            sat = {1'b1, {(OUT_W-1){1'b0}}};
        else
            sat = {1'b0, {(OUT_W-1){1'b1}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_dig    <= '0;
            r_cep    <= '0;
            r_bin    <= '0;
            r_strobe <= 1'b0;
            for (int k = 0; k < NUM_CEPS; k++)
                r_acc[k] <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_x     <= i_log_energy;
                        r_dig   <= '0;
                        r_cep   <= '0;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_acc[r_cep] <= acc_sel + term;
                    // rotate so the energy is whole again after four digits
                    r_x   <= {r_x[DIG_W-1:0], r_x[X_W-1:DIG_W]};
                    r_dig <= r_dig + lcd_pkg::DIG_CNT_W'(1);
                    if (r_dig == lcd_pkg::LAST_DIG) begin
                        if (r_cep == LAST_CEP) begin
                            r_cep <= '0;
                            if (r_bin == LAST_BIN) begin
                                r_bin   <= '0;
                                r_state <= ST_EMIT;
                            end else begin
                                r_bin   <= r_bin + BIN_W'(1);
                                r_state <= ST_IDLE;
                            end
                        end else begin
                            r_cep <= r_cep + CEP_W'(1);
                        end
                    end
                end
                ST_EMIT: begin
                    r_acc[r_cep] <= '0;
                    r_strobe     <= 1'b1;
                    r_idx        <= r_cep;
                    r_ceps       <= sat;
                    r_last       <= (r_cep == LAST_CEP);
                    if (r_cep == LAST_CEP) begin
                        r_cep   <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cep <= r_cep + CEP_W'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_coef_index = lcd_pkg::IDX_W'(r_idx);
    assign o_cepstrum   = r_ceps;
    assign o_last_coef  = r_last;

endmodule

`default_nettype wire

[hw/rtl/lcd_checker.sv]
`default_nettype none

module lcd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_strobe,
    input wire logic [lcd_pkg::IDX_W-1:0]     o_coef_index,
    input wire logic                          o_last_coef
);

    // an accepted item always holds the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // results only come out of a burst that started while busy
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobed without prior busy");

    // a burst starts at index 0
    a_first_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !$past(o_strobe) |-> o_coef_index == '0)
        else $error("frame burst did not start at index 0");

    // inside a burst indices step by one on back-to-back cycles
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_coef |=>
            o_strobe && o_coef_index == lcd_pkg::IDX_W'($past(o_coef_index) + 1'b1))
        else $error("burst index did not advance");

    // the last coefficient closes the burst
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_coef |=> !o_strobe)
        else $error("result after last coefficient");

endmodule

bind liftered_dct_cepstrum_top lcd_checker u_lcd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_coef_index (o_coef_index),
    .o_last_coef  (o_last_coef)
);

`default_nettype wire
